>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the sorter RTL.
// No dependencies; SYNTH removes the checks from synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

>>> hw/rtl/bs_pkg.sv
// Types and constants of the bitonic sorter.
// No dependencies; imported by bitonic_sorter_core.
`default_nettype none

package bs_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CfgW   = 4;

  localparam logic [CfgW-1:0] SetSizeLogReset = 4'd10;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OUT,
    ST_SRD,
    ST_SCMP,
    ST_SWR
  } sorter_state_e;

  typedef struct packed {
    logic              func;
    logic [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] sorted_value;
    logic              last;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/bitonic_sorter_core.sv
// Bitonic sorter top level: APB register, item control, in-place sort sequencer.
// Depends on bs_pkg, bs_ram and assert_macros.svh.
// A load item is written as it is accepted; a read item's result is strobed by done_o in the
// cycle after acceptance, while busy is high. The load completing a set of N = 2^L values
// starts the sort, busy high to its end: two writes per compare-exchange, one write port.
// Reset clears control state only; the store is not cleared and the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"

module bitonic_sorter_core
  import bs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item_i,
  output logic             done_o,
  output out_item_t        out_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW     = $clog2(MAX_ELEMENTS);
  localparam int unsigned LW     = $clog2(AW + 1);
  localparam int unsigned LG_MAX = $clog2(MAX_ELEMENTS + 1) - 1;

  sorter_state_e state_q, state_d;
  logic [CfgW-1:0]   cfg_q, cfg_d;
  logic [AW:0]       load_count_q, load_count_d;
  logic [AW-1:0]     read_index_q, read_index_d;
  logic              readout_q, readout_d;
  logic              last_q, last_d;
  logic [LW-1:0]     kl_q, kl_d, jl_q, jl_d;
  logic [AW-1:0]     c_q, c_d;
  logic [ValueW-1:0] hi_q, hi_d;

  logic [LW-1:0]     lg;
  logic [AW:0]       n, n_m1;
  logic [AW-1:0]     half_m1, c_rd, low_mask, j_bit;
  logic [AW-1:0]     lo_cur, hi_cur, lo_rd, hi_rd;
  logic [AW:0]       lo_ext;
  logic              up, swap, sorting, cfg_we;
  logic              we;
  logic [AW-1:0]     waddr, raddr_a;
  logic [ValueW-1:0] wdata, rdata_a, rdata_b;

  assign pready = 1'b1;
  assign prdata = 32'(cfg_q);
  assign cfg_we = psel && penable && pwrite;
  assign cfg_d  = pwdata[CfgW-1:0];

  always_comb begin
    if (cfg_q == '0) begin
      lg = LW'(1);
    end else if (int'(cfg_q) > int'(LG_MAX)) begin
      lg = LW'(LG_MAX);
    end else begin
      lg = LW'(cfg_q);
    end
  end

  assign n       = (AW+1)'(1) << lg;
  assign n_m1    = n - (AW+1)'(1);
  assign half_m1 = AW'(n >> 1) - AW'(1);

  assign j_bit    = AW'(1) << jl_q;
  assign low_mask = j_bit - AW'(1);
  assign c_rd     = (state_q == ST_SWR) ? c_q + AW'(1) : c_q;
  assign lo_cur   = ((c_q & ~low_mask) << 1) | (c_q & low_mask);
  assign hi_cur   = lo_cur | j_bit;
  assign lo_rd    = ((c_rd & ~low_mask) << 1) | (c_rd & low_mask);
  assign hi_rd    = lo_rd | j_bit;
  assign lo_ext   = {1'b0, lo_cur};
  assign up       = ~lo_ext[kl_q];
  assign swap     = up ? (rdata_a > rdata_b) : (rdata_a < rdata_b);

  assign sorting = (state_q == ST_SRD) || (state_q == ST_SCMP) || (state_q == ST_SWR);
  assign raddr_a = sorting ? lo_rd : read_index_q;
  assign busy    = (state_q != ST_IDLE);

  always_comb begin
    state_d      = state_q;
    load_count_d = load_count_q;
    read_index_d = read_index_q;
    readout_d    = readout_q;
    last_d       = last_q;
    kl_d         = kl_q;
    jl_d         = jl_q;
    c_d          = c_q;
    hi_d         = hi_q;
    we           = 1'b0;
    waddr        = load_count_q[AW-1:0];
    wdata        = in_item_i.value;
    done_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (in_item_i.func == FUNC_LOAD) begin
            if (!readout_q) begin
              we = 1'b1;
              if (load_count_q + (AW+1)'(1) == n) begin
                load_count_d = '0;
                read_index_d = '0;
                kl_d         = LW'(1);
                jl_d         = '0;
                c_d          = '0;
                state_d      = ST_SRD;
              end else begin
                load_count_d = load_count_q + (AW+1)'(1);
              end
            end
          end else if (readout_q) begin
            last_d  = ({1'b0, read_index_q} == n_m1);
            state_d = ST_OUT;
            if ({1'b0, read_index_q} == n_m1) begin
              readout_d    = 1'b0;
              read_index_d = '0;
              load_count_d = '0;
            end else begin
              read_index_d = read_index_q + AW'(1);
            end
          end
        end
      end
      ST_OUT: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SRD: begin
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        we      = 1'b1;
        waddr   = lo_cur;
        wdata   = swap ? rdata_b : rdata_a;
        hi_d    = swap ? rdata_a : rdata_b;
        state_d = ST_SWR;
      end
      ST_SWR: begin
        we    = 1'b1;
        waddr = hi_cur;
        wdata = hi_q;
        if (c_q != half_m1) begin
          c_d     = c_q + AW'(1);
          state_d = ST_SCMP;
        end else begin
          c_d = '0;
          if (jl_q == '0) begin
            if (kl_q == lg) begin
              readout_d = 1'b1;
              state_d   = ST_IDLE;
            end else begin
              kl_d    = LW'(kl_q + LW'(1));
              jl_d    = kl_q;
              state_d = ST_SRD;
            end
          end else begin
            jl_d    = jl_q - LW'(1);
            state_d = ST_SRD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      load_count_d = '0;
      read_index_d = '0;
      readout_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_q        <= SetSizeLogReset;
      load_count_q <= '0;
      read_index_q <= '0;
      readout_q    <= 1'b0;
      kl_q         <= '0;
      jl_q         <= '0;
      c_q          <= '0;
    end else begin
      state_q      <= state_d;
      load_count_q <= load_count_d;
      read_index_q <= read_index_d;
      readout_q    <= readout_d;
      kl_q         <= kl_d;
      jl_q         <= jl_d;
      c_q          <= c_d;
      if (cfg_we) begin
        cfg_q <= cfg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    hi_q   <= hi_d;
  end

  bs_ram #(
    .Width (ValueW),
    .Depth (MAX_ELEMENTS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (hi_rd),
    .rdata_b_o (rdata_b)
  );

  assign out_item_o.sorted_value = rdata_a;
  assign out_item_o.last         = last_q;

  `ASSERT_PROP(a_done_follows_read, clk_i, rst_ni,
    done_o |-> $past(start && !busy && in_item_i.func == FUNC_READ && readout_q))
  `ASSERT_PROP(a_stage_order, clk_i, rst_ni,
    sorting |-> (jl_q < kl_q && kl_q <= lg))
  `ASSERT_PROP(a_sort_ends_in_readout, clk_i, rst_ni,
    (state_q == ST_SWR && state_d == ST_IDLE) |=> readout_q)
  `ASSERT_NEVER(a_no_load_in_readout, clk_i, rst_ni,
    we && state_q == ST_IDLE && readout_q)

endmodule

`default_nettype wire

>>> hw/rtl/bs_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module bs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  output logic      [Width-1:0] rdata_a_o,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire
